### src/qdw_pkg.sv
package qdw_pkg;

	// Fixed-point format of every field.
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Squared speed at or below this is treated as standing still (|v| <= 1e-3).
	localparam logic [63:0] SPEED_SQ_FLOOR =
		64'((64'd1 << (2 * FRAC_BITS - 1)) / 64'd500000);

	// Square root and divider each resolve two bits per stage.
	localparam int ROOT_BITS  = 32;
	localparam int SQ_STAGES  = ROOT_BITS / 2;
	localparam int DIV_STAGES = ROOT_BITS / 2;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_BITS  = 296;
	localparam int OUT_BITS = 200;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DENSITY    = 3'd0,
		REG_AREA       = 3'd1,
		REG_LIN_CD     = 3'd2,
		REG_ANG_CD     = 3'd3,
		REG_FORCE_LIM  = 3'd4,
		REG_TORQUE_LIM = 3'd5
	} reg_idx_t;

	typedef logic signed [31:0] word_t;
	typedef logic [31:0] uword_t;

	// Coefficient set for one drag vector, derived from the registers.
	typedef struct packed {
		logic [46:0] k;
		logic        k_ovf;
		logic [31:0] limit;
	} vcoef_t;

	// Partial state of the digit-by-digit square root.
	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_t;

	// Partial state of the restoring divider.
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
	} div_t;

	// One result bit of the square root from the next two radicand bits.
	function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] d);
		logic [35:0] r;
		logic [35:0] tr;
		sqrt_t       o;
		r  = {s.rem, d};
		tr = {2'b00, s.root, 2'b01};
		if (r >= tr) begin
			o.rem  = 34'(r - tr);
			o.root = {s.root[30:0], 1'b1};
		end else begin
			o.rem  = r[33:0];
			o.root = {s.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// One quotient bit of the divider from the next dividend bit.
	function automatic div_t div_step(div_t s, logic nb, logic [31:0] den);
		logic [32:0] r;
		div_t        o;
		r = {s.rem, nb};
		if (r >= {1'b0, den}) begin
			o.rem = 32'(r - {1'b0, den});
			o.quo = {s.quo[30:0], 1'b1};
		end else begin
			o.rem = r[31:0];
			o.quo = {s.quo[30:0], 1'b0};
		end
		return o;
	endfunction

endpackage

### src/qdw_drag_vec.sv
module qdw_drag_vec import qdw_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  logic   bad,
	input  word_t  v [3],
	input  vcoef_t coef,
	output word_t  res [3],
	output logic   ovf,
	output logic   vld_out
);

	typedef struct packed {
		logic             bad;
		logic             slow;
		logic [2:0]       pos;
		logic [2:0][31:0] a;
	} side_t;

	typedef struct packed {
		logic             ovf;
		logic             kill;
		logic [2:0]       pos;
		logic [2:0][30:0] m;
	} side2_t;

	// Stage 1: component magnitudes and signs.
	logic   vld_s1;
	logic   bad_s1;
	logic [2:0] pos_s1;
	uword_t a_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= bad;
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= (v[i] > 0);
				a_s1[i]   <= v[i][31] ? uword_t'(-v[i]) : uword_t'(v[i]);
			end
		end
	end

	// Stage 2: squares.
	logic        vld_s2;
	logic        bad_s2;
	logic [2:0]  pos_s2;
	uword_t      a_s2 [3];
	logic [63:0] sq_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s2 <= bad_s1;
			pos_s2 <= pos_s1;
			for (int i = 0; i < 3; i++) begin
				a_s2[i]  <= a_s1[i];
				sq_s2[i] <= {32'd0, a_s1[i]} * {32'd0, a_s1[i]};
			end
		end
	end

	// Stage 3: squared speed and the standstill test, entering the speed root.
	logic [63:0] s2sum;
	side_t       side_in;

	always_comb begin
		s2sum        = sq_s2[0] + sq_s2[1] + sq_s2[2];
		side_in.bad  = bad_s2;
		side_in.slow = (s2sum <= SPEED_SQ_FLOOR);
		side_in.pos  = pos_s2;
		for (int i = 0; i < 3; i++) side_in.a[i] = a_s2[i];
	end

	sqrt_t       spd_sr_s  [SQ_STAGES+1];
	logic [63:0] spd_rad_s [SQ_STAGES+1];
	side_t       spd_sd_s  [SQ_STAGES+1];
	logic        spd_vld_s [SQ_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) spd_vld_s[0] <= 1'b0;
		else if (en) spd_vld_s[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spd_sr_s[0]  <= '0;
			spd_rad_s[0] <= s2sum;
			spd_sd_s[0]  <= side_in;
		end
	end

	// Speed square root, two result bits per stage.
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_spd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) spd_vld_s[j+1] <= 1'b0;
			else if (en) spd_vld_s[j+1] <= spd_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				spd_sr_s[j+1]  <= sqrt_step(sqrt_step(spd_sr_s[j], spd_rad_s[j][63:62]),
					spd_rad_s[j][61:60]);
				spd_rad_s[j+1] <= {spd_rad_s[j][59:0], 4'b0000};
				spd_sd_s[j+1]  <= spd_sd_s[j];
			end
		end
	end

	// Stage 20: partial products of k times speed.
	logic        vld_s20;
	side_t       sd_s20;
	logic [63:0] plo_s20;
	logic [46:0] phi_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s20 <= 1'b0;
		else if (en) vld_s20 <= spd_vld_s[SQ_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s20  <= spd_sd_s[SQ_STAGES];
			plo_s20 <= {32'd0, coef.k[31:0]} * {32'd0, spd_sr_s[SQ_STAGES].root};
			phi_s20 <= {32'd0, coef.k[46:32]} * {15'd0, spd_sr_s[SQ_STAGES].root};
		end
	end

	// Stage 21: combine into q and check for a product beyond 64 bits.
	logic        vld_s21;
	side_t       sd_s21;
	logic        t_ovf_s21;
	logic [47:0] q_s21;
	logic [79:0] t_full;

	assign t_full = {16'd0, plo_s20} + {1'b0, phi_s20, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s21 <= 1'b0;
		else if (en) vld_s21 <= vld_s20;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s21    <= sd_s20;
			t_ovf_s21 <= |t_full[79:64];
			q_s21     <= t_full[63:16];
		end
	end

	// Stage 22: partial products of q times each component magnitude.
	logic        vld_s22;
	side_t       sd_s22;
	logic        t_ovf_s22;
	logic [63:0] pl_s22 [3];
	logic [47:0] ph_s22 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s22 <= 1'b0;
		else if (en) vld_s22 <= vld_s21;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s22    <= sd_s21;
			t_ovf_s22 <= t_ovf_s21;
			for (int i = 0; i < 3; i++) begin
				pl_s22[i] <= {32'd0, q_s21[31:0]} * {32'd0, sd_s21.a[i]};
				ph_s22[i] <= {32'd0, q_s21[47:32]} * {16'd0, sd_s21.a[i]};
			end
		end
	end

	// Stage 23: component magnitudes and the overflow decision.
	logic        vld_s23;
	side2_t      sd2_s23;
	logic [79:0] prod [3];
	logic [2:0]  m_ovf;
	side2_t      sd2_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i]     = {16'd0, pl_s22[i]} + {ph_s22[i], 32'd0};
			m_ovf[i]    = |prod[i][79:47];
			sd2_in.m[i] = prod[i][46:16];
		end
		sd2_in.ovf  = sd_s22.bad
			| (!sd_s22.slow & (coef.k_ovf | t_ovf_s22 | (|m_ovf)));
		sd2_in.kill = sd_s22.slow | sd2_in.ovf;
		sd2_in.pos  = sd_s22.pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s23 <= 1'b0;
		else if (en) vld_s23 <= vld_s22;
	end

	always_ff @(posedge clk) begin
		if (en) sd2_s23 <= sd2_in;
	end

	// Stage 24: squared component magnitudes.
	logic        vld_s24;
	side2_t      sd2_s24;
	logic [61:0] msq_s24 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s24 <= 1'b0;
		else if (en) vld_s24 <= vld_s23;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd2_s24 <= sd2_s23;
			for (int i = 0; i < 3; i++)
				msq_s24[i] <= {31'd0, sd2_s23.m[i]} * {31'd0, sd2_s23.m[i]};
		end
	end

	// Stage 25: squared magnitude, entering the magnitude root.
	sqrt_t       mg_sr_s  [SQ_STAGES+1];
	logic [63:0] mg_rad_s [SQ_STAGES+1];
	side2_t      mg_sd_s  [SQ_STAGES+1];
	logic        mg_vld_s [SQ_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mg_vld_s[0] <= 1'b0;
		else if (en) mg_vld_s[0] <= vld_s24;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mg_sr_s[0]  <= '0;
			mg_rad_s[0] <= {2'd0, msq_s24[0]} + {2'd0, msq_s24[1]} + {2'd0, msq_s24[2]};
			mg_sd_s[0]  <= sd2_s24;
		end
	end

	// Magnitude square root, two result bits per stage.
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_mag
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) mg_vld_s[j+1] <= 1'b0;
			else if (en) mg_vld_s[j+1] <= mg_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mg_sr_s[j+1]  <= sqrt_step(sqrt_step(mg_sr_s[j], mg_rad_s[j][63:62]),
					mg_rad_s[j][61:60]);
				mg_rad_s[j+1] <= {mg_rad_s[j][59:0], 4'b0000};
				mg_sd_s[j+1]  <= mg_sd_s[j];
			end
		end
	end

	// Stage 42: limit test and dividends m times limit, entering the dividers.
	logic [31:0] mag;
	logic [62:0] num [3];

	assign mag = mg_sr_s[SQ_STAGES].root;

	always_comb begin
		for (int i = 0; i < 3; i++)
			num[i] = {32'd0, mg_sd_s[SQ_STAGES].m[i]} * {31'd0, coef.limit};
	end

	div_t        dv_s     [DIV_STAGES+1][3];
	logic [31:0] dlow_s   [DIV_STAGES+1][3];
	logic [31:0] dmag_s   [DIV_STAGES+1];
	logic        dscale_s [DIV_STAGES+1];
	side2_t      dsd_s    [DIV_STAGES+1];
	logic        dvld_s   [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvld_s[0] <= 1'b0;
		else if (en) dvld_s[0] <= mg_vld_s[SQ_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s[0]   <= mag;
			dscale_s[0] <= (coef.limit != 32'd0) && (mag > coef.limit) && (mag != 32'd0);
			dsd_s[0]    <= mg_sd_s[SQ_STAGES];
			for (int i = 0; i < 3; i++) begin
				dv_s[0][i].rem <= {1'b0, num[i][62:32]};
				dv_s[0][i].quo <= '0;
				dlow_s[0][i]   <= num[i][31:0];
			end
		end
	end

	// Three restoring dividers by the magnitude, two quotient bits per stage.
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvld_s[j+1] <= 1'b0;
			else if (en) dvld_s[j+1] <= dvld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dmag_s[j+1]   <= dmag_s[j];
				dscale_s[j+1] <= dscale_s[j];
				dsd_s[j+1]    <= dsd_s[j];
				for (int i = 0; i < 3; i++) begin
					dv_s[j+1][i]   <= div_step(div_step(dv_s[j][i], dlow_s[j][i][31], dmag_s[j]),
						dlow_s[j][i][30], dmag_s[j]);
					dlow_s[j+1][i] <= {dlow_s[j][i][29:0], 2'b00};
				end
			end
		end
	end

	// Stage 59: pick scaled or plain magnitude, apply the opposing sign; zero on standstill or overflow.
	logic   vld_s59;
	logic   ovf_s59;
	word_t  res_s59 [3];
	uword_t val [3];
	side2_t fsd;

	assign fsd = dsd_s[DIV_STAGES];

	always_comb begin
		for (int i = 0; i < 3; i++)
			val[i] = dscale_s[DIV_STAGES] ? dv_s[DIV_STAGES][i].quo : {1'b0, fsd.m[i]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s59 <= 1'b0;
		else if (en) vld_s59 <= dvld_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s59 <= fsd.ovf;
			for (int i = 0; i < 3; i++) begin
				if (fsd.kill) res_s59[i] <= '0;
				else if (fsd.pos[i]) res_s59[i] <= word_t'(-val[i]);
				else res_s59[i] <= word_t'(val[i]);
			end
		end
	end

	assign res     = res_s59;
	assign ovf     = ovf_s59;
	assign vld_out = vld_s59;

endmodule

### src/quadratic_drag_wrench_top.sv
// Quadratic drag wrench: force and torque opposing a body's motion.
// Input stream s_axis carries one body per transfer: linear velocity, wind with
// its valid bit and angular velocity, all signed Q16.16. Output stream m_axis
// carries the force, the torque, the apply flag and the overflow flag.
// The configuration port writes density, area, both drag coefficients and both
// magnitude limits; the user must see that it is written only while no transfers
// are in flight, as the block itself does not enforce this. One transfer is
// accepted per cycle while the skid register is empty. Each result passes through
// the two 16-stage square roots and the 16-stage limit dividers, two bits per stage each.
// Reset clears the valid bits and loads the register defaults; the derived
// coefficients settle through the kp_q, klo_q/khi_q and coef_q registers, well
// before an item needs them. When the receiver stalls, the result is held in the
// output register, the pipeline passes its next result into a skid register and
// then holds, so nothing is lost or repeated.
module quadratic_drag_wrench_top import qdw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// body_vel_x, body_vel_y, body_vel_z, wind_x, wind_y, wind_z, wind_valid,
	// spin_x, spin_y, spin_z, then zero padding
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z, apply_wrench,
	// overflow, then zero padding
	output logic [OUT_BITS-1:0] m_axis_tdata
);

	logic en;

	// Configuration registers.
	logic [31:0] dens_q, area_q, lin_cd_q, ang_cd_q, flim_q, tlim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dens_q   <= 32'd80282;
			area_q   <= 32'd65536;
			lin_cd_q <= 32'd65536;
			ang_cd_q <= 32'd65536;
			flim_q   <= 32'd65536000;
			tlim_q   <= 32'd65536000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DENSITY:    dens_q   <= cfg_data;
				REG_AREA:       area_q   <= cfg_data;
				REG_LIN_CD:     lin_cd_q <= cfg_data;
				REG_ANG_CD:     ang_cd_q <= cfg_data;
				REG_FORCE_LIM:  flim_q   <= cfg_data;
				REG_TORQUE_LIM: tlim_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficient k = ((rho*Cd >> F) * A) >> (F+1), computed in kp_q, klo_q/khi_q, coef_q.
	logic [31:0] cd [2];
	logic [31:0] lim [2];
	logic [63:0] kp_q [2];
	logic [63:0] klo_q [2];
	logic [47:0] khi_q [2];
	logic [79:0] k2 [2];
	vcoef_t      coef_q [2];

	assign cd[0]  = lin_cd_q;
	assign cd[1]  = ang_cd_q;
	assign lim[0] = flim_q;
	assign lim[1] = tlim_q;

	always_comb begin
		for (int i = 0; i < 2; i++)
			k2[i] = {16'd0, klo_q[i]} + {khi_q[i], 32'd0};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			kp_q[i]         <= {32'd0, dens_q} * {32'd0, cd[i]};
			klo_q[i]        <= {32'd0, kp_q[i][47:16]} * {32'd0, area_q};
			khi_q[i]        <= {16'd0, kp_q[i][63:48]} * {16'd0, area_q};
			coef_q[i].k     <= k2[i][63:17];
			coef_q[i].k_ovf <= |k2[i][79:64];
			coef_q[i].limit <= lim[i];
		end
	end

	// Stage 1: relative velocity and its range check.
	logic        vld_s1;
	logic        bad_s1;
	word_t       rel_s1 [3];
	word_t       spin_s1 [3];
	logic        wv;
	logic signed [32:0] rel [3];

	assign wv = s_axis_tdata[192];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rel[i] = {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
				- (wv ? {s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i +: 32]} : 33'sd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s1 <= (rel[0][32] ^ rel[0][31]) | (rel[1][32] ^ rel[1][31])
				| (rel[2][32] ^ rel[2][31]);
			for (int i = 0; i < 3; i++) begin
				rel_s1[i]  <= rel[i][31:0];
				spin_s1[i] <= s_axis_tdata[193+32*i +: 32];
			end
		end
	end

	// Force and torque pipelines run in lockstep.
	word_t f_res [3];
	word_t t_res [3];
	logic  f_ovf, t_ovf, f_vld;

	qdw_drag_vec u_force (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s1),
		.bad     (bad_s1),
		.v       (rel_s1),
		.coef    (coef_q[0]),
		.res     (f_res),
		.ovf     (f_ovf),
		.vld_out (f_vld)
	);

	qdw_drag_vec u_torque (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s1),
		.bad     (1'b0),
		.v       (spin_s1),
		.coef    (coef_q[1]),
		.res     (t_res),
		.ovf     (t_ovf),
		.vld_out ()
	);

	// Stage 60: flags and result packing.
	logic                vld_s60;
	logic [OUT_BITS-1:0] out_s60;
	logic                apply;

	assign apply = (f_res[0] != 0) | (f_res[1] != 0) | (f_res[2] != 0)
		| (t_res[0] != 0) | (t_res[1] != 0) | (t_res[2] != 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s60 <= 1'b0;
		else if (en) vld_s60 <= f_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s60 <= {6'd0, f_ovf | t_ovf, apply, t_res[2], t_res[1], t_res[0],
				f_res[2], f_res[1], f_res[0]};
		end
	end

	// Output register with a skid register behind it.
	logic                out_vld_q, skid_vld_q;
	logic [OUT_BITS-1:0] out_data_q, skid_data_q;
	logic                out_free;

	assign out_free = !out_vld_q || m_axis_tready;
	assign en       = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_free) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s60) begin
			if (out_free) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (out_free) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_free) out_data_q <= skid_data_q;
		end else if (vld_s60) begin
			if (out_free) out_data_q <= out_s60;
			else skid_data_q <= out_s60;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
